/* hw/rtl/nbcd_pkg.sv */
package nbcd_pkg;

  localparam int unsigned PhaseW   = 3;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 3;

  localparam logic [PhaseW-1:0] PH_A1 = 3'd0;
  localparam logic [PhaseW-1:0] PH_A2 = 3'd1;
  localparam logic [PhaseW-1:0] PH_A3 = 3'd2;
  localparam logic [PhaseW-1:0] PH_M1 = 3'd3;
  localparam logic [PhaseW-1:0] PH_M2 = 3'd4;
  localparam logic [PhaseW-1:0] PH_X1 = 3'd5;
  localparam logic [PhaseW-1:0] PH_X2 = 3'd6;
  localparam logic [PhaseW-1:0] PH_X3 = 3'd7;

  localparam logic [KindW-1:0] KIND_NORMAL    = 3'd0;
  localparam logic [KindW-1:0] KIND_COND_JUMP = 3'd1;
  localparam logic [KindW-1:0] KIND_FETCH_IMM = 3'd2;
  localparam logic [KindW-1:0] KIND_JUMP      = 3'd3;
  localparam logic [KindW-1:0] KIND_CALL      = 3'd4;
  localparam logic [KindW-1:0] KIND_INC_SKIP  = 3'd5;

  localparam logic [NibbleW-1:0] OPC_COND_JUMP = 4'h1;
  localparam logic [NibbleW-1:0] OPC_FETCH_IMM = 4'h2;
  localparam logic [NibbleW-1:0] OPC_JUMP      = 4'h4;
  localparam logic [NibbleW-1:0] OPC_CALL      = 4'h5;
  localparam logic [NibbleW-1:0] OPC_INC_SKIP  = 4'h7;

  typedef struct packed {
    logic [NibbleW-1:0] bus_pins;
    logic               sync_level;
    logic               clock_order_ok;
  } in_beat_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [NibbleW-1:0] data_nibble;
    logic [AddrW-1:0]   instr_address;
    logic [ByteW-1:0]   instr_byte;
    logic [KindW-1:0]   pending_kind;
    logic [NibbleW-1:0] pending_operand;
    logic [NibbleW-1:0] nibble_at_x2;
    logic               cycle_done;
  } out_beat_t;

  typedef struct packed {
    logic step;
    logic produce;
  } step_ctl_t;

  function automatic logic [KindW-1:0] classify(input logic [ByteW-1:0] ib);
    logic [KindW-1:0] k;
    k = KIND_NORMAL;
    case (ib[ByteW-1:NibbleW])
      OPC_COND_JUMP: k = KIND_COND_JUMP;
      OPC_FETCH_IMM: k = ib[0] ? KIND_NORMAL : KIND_FETCH_IMM;
      OPC_JUMP:      k = KIND_JUMP;
      OPC_CALL:      k = KIND_CALL;
      OPC_INC_SKIP:  k = KIND_INC_SKIP;
      default:       k = KIND_NORMAL;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/nbcd_in_stage.sv */
module nbcd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nbcd_pkg::in_beat_t in_data,
  input  logic              advance,
  output logic              beat_valid,
  output nbcd_pkg::in_beat_t beat
);

  logic               valid_r;
  logic               valid_nxt;
  nbcd_pkg::in_beat_t beat_r;

  assign in_stall  = valid_r & ~advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat_r <= in_data;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

/* hw/rtl/nbcd_core.sv */
module nbcd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  nbcd_pkg::in_beat_t  beat,
  output nbcd_pkg::step_ctl_t ctl,
  output nbcd_pkg::out_beat_t result
);

  logic                             locked_r, locked_nxt;
  logic [nbcd_pkg::PhaseW-1:0]      phase_r, phase_nxt;
  logic [nbcd_pkg::AddrW-1:0]       addr_r, addr_nxt;
  logic [nbcd_pkg::ByteW-1:0]       instr_r, instr_nxt;
  logic [nbcd_pkg::KindW-1:0]       kind_r, kind_nxt;
  logic [nbcd_pkg::NibbleW-1:0]     oper_r, oper_nxt;
  logic [nbcd_pkg::NibbleW-1:0]     x2_r, x2_nxt;
  logic [nbcd_pkg::NibbleW-1:0]     bus;
  logic [nbcd_pkg::PhaseW-1:0]      next_ph;
  logic                             sync_on;
  logic                             produce;

  assign bus     = ~beat.bus_pins;
  assign sync_on = ~beat.sync_level;
  assign next_ph = phase_r + 3'd1;

  always_comb begin
    locked_nxt = locked_r;
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    instr_nxt  = instr_r;
    kind_nxt   = kind_r;
    oper_nxt   = oper_r;
    x2_nxt     = x2_r;
    produce    = 1'b0;
    if (step) begin
      if (!locked_r) begin
        if (sync_on && beat.clock_order_ok) begin
          locked_nxt = 1'b1;
          phase_nxt  = nbcd_pkg::PH_X3;
          kind_nxt   = nbcd_pkg::KIND_NORMAL;
          oper_nxt   = '0;
        end
      end else if (!beat.clock_order_ok || ((phase_r == nbcd_pkg::PH_X2) != sync_on)) begin
        locked_nxt = 1'b0;
        kind_nxt   = nbcd_pkg::KIND_NORMAL;
        oper_nxt   = '0;
      end else begin
        produce   = 1'b1;
        phase_nxt = next_ph;
        case (next_ph)
          nbcd_pkg::PH_A1: begin
            oper_nxt = instr_r[nbcd_pkg::NibbleW-1:0];
            kind_nxt = (kind_r != nbcd_pkg::KIND_NORMAL) ? nbcd_pkg::KIND_NORMAL
                                                         : nbcd_pkg::classify(instr_r);
            addr_nxt = {addr_r[11:4], bus};
          end
          nbcd_pkg::PH_A2: addr_nxt  = {addr_r[11:8], bus, addr_r[3:0]};
          nbcd_pkg::PH_A3: addr_nxt  = {bus, addr_r[7:0]};
          nbcd_pkg::PH_M1: instr_nxt = {bus, instr_r[3:0]};
          nbcd_pkg::PH_M2: instr_nxt = {instr_r[7:4], bus};
          nbcd_pkg::PH_X2: x2_nxt    = bus;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      phase_r  <= nbcd_pkg::PH_A1;
      addr_r   <= '0;
      instr_r  <= '0;
      kind_r   <= nbcd_pkg::KIND_NORMAL;
      oper_r   <= '0;
      x2_r     <= '0;
    end else begin
      locked_r <= locked_nxt;
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      instr_r  <= instr_nxt;
      kind_r   <= kind_nxt;
      oper_r   <= oper_nxt;
      x2_r     <= x2_nxt;
    end
  end

  assign ctl.step    = step;
  assign ctl.produce = produce;

  assign result.phase           = phase_nxt;
  assign result.data_nibble     = bus;
  assign result.instr_address   = addr_nxt;
  assign result.instr_byte      = instr_nxt;
  assign result.pending_kind    = kind_nxt;
  assign result.pending_operand = oper_nxt;
  assign result.nibble_at_x2    = x2_nxt;
  assign result.cycle_done      = (phase_nxt == nbcd_pkg::PH_X3);

endmodule

/* hw/rtl/nbcd_out_stage.sv */
module nbcd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  nbcd_pkg::step_ctl_t ctl,
  input  nbcd_pkg::out_beat_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output nbcd_pkg::out_beat_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  nbcd_pkg::out_beat_t data_r;

  assign advance   = ~valid_r | ~out_stall;
  assign valid_nxt = advance ? (ctl.step & ctl.produce) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl.produce) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hw/rtl/nibble_bus_cycle_decoder.sv */
// Decodes a four-bit multiplexed bus, one bus-phase sample per input beat.
// Input channel: in_valid, in_stall and in_data carrying the raw active-low
// data pins, the raw sync level and the clock-order flag of one phase.
// Result channel: out_valid, out_stall and out_data carrying the phase, the
// inverted nibble, the assembled address and instruction byte, the pending
// two-word kind and operand, the nibble seen in X2 and the cycle-done flag.
// Samples taken while searching for sync, and samples dropped on a clock-order
// error or a misplaced sync, produce no result beat.
// A beat accepted into the input register passes through the phase logic, is
// loaded into the result register and is offered from there until taken.
// Throughput is one beat per cycle while out_stall is low, set by one pass
// from the input register through the phase logic into the result register.
// When the receiver stalls, the result register holds its beat, the input
// register holds the next one, and in_stall rises only once both are full.
// Reset clears the lock, the phase, the assembled registers and both valid
// flags; the block then looks for the next asserted sync.
module nibble_bus_cycle_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nbcd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nbcd_pkg::out_beat_t out_data
);

  logic                beat_valid;
  logic                advance;
  nbcd_pkg::in_beat_t  beat;
  nbcd_pkg::step_ctl_t ctl;
  nbcd_pkg::out_beat_t result;

  nbcd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .advance   (advance),
    .beat_valid(beat_valid),
    .beat      (beat)
  );

  nbcd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (beat_valid & advance),
    .beat  (beat),
    .ctl   (ctl),
    .result(result)
  );

  nbcd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .result   (result),
    .advance  (advance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* verif/nbcd_checker.sv */
module nbcd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  nbcd_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  nbcd_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  results_left,
  output int                  results_checked,
  output logic [7:0]          kinds_seen
);

  logic                         locked;
  logic [nbcd_pkg::PhaseW-1:0]  cur_phase;
  logic [nbcd_pkg::AddrW-1:0]   addr_acc;
  logic [nbcd_pkg::ByteW-1:0]   instr_acc;
  logic [nbcd_pkg::KindW-1:0]   kind_now;
  logic [nbcd_pkg::NibbleW-1:0] operand_now;
  logic [nbcd_pkg::NibbleW-1:0] x2_nibble;
  nbcd_pkg::out_beat_t          decoded_beats[$];

  initial fail_count = 0;

  function automatic logic [nbcd_pkg::KindW-1:0] first_word_kind(
    input logic [nbcd_pkg::ByteW-1:0] ib
  );
    logic [nbcd_pkg::KindW-1:0] k;
    case (ib[7:4])
      nbcd_pkg::OPC_COND_JUMP: k = nbcd_pkg::KIND_COND_JUMP;
      nbcd_pkg::OPC_FETCH_IMM: k = ib[0] ? nbcd_pkg::KIND_NORMAL : nbcd_pkg::KIND_FETCH_IMM;
      nbcd_pkg::OPC_JUMP:      k = nbcd_pkg::KIND_JUMP;
      nbcd_pkg::OPC_CALL:      k = nbcd_pkg::KIND_CALL;
      nbcd_pkg::OPC_INC_SKIP:  k = nbcd_pkg::KIND_INC_SKIP;
      default:                 k = nbcd_pkg::KIND_NORMAL;
    endcase
    return k;
  endfunction

  task automatic decode_sample(input nbcd_pkg::in_beat_t b);
    logic [nbcd_pkg::NibbleW-1:0] nib;
    logic                         sync_on;
    logic [nbcd_pkg::PhaseW-1:0]  nxt;
    nbcd_pkg::out_beat_t          r;
    nib = ~b.bus_pins;
    sync_on = !b.sync_level;
    if (!locked) begin
      if (sync_on && b.clock_order_ok) begin
        locked = 1'b1;
        cur_phase = nbcd_pkg::PH_X3;
        kind_now = nbcd_pkg::KIND_NORMAL;
        operand_now = '0;
      end
    end else if (!b.clock_order_ok || ((cur_phase == nbcd_pkg::PH_X2) != sync_on)) begin
      locked = 1'b0;
      kind_now = nbcd_pkg::KIND_NORMAL;
      operand_now = '0;
    end else begin
      nxt = cur_phase + 3'd1;
      case (nxt)
        nbcd_pkg::PH_A1: begin
          operand_now = instr_acc[3:0];
          kind_now = (kind_now != nbcd_pkg::KIND_NORMAL) ? nbcd_pkg::KIND_NORMAL
                                                         : first_word_kind(instr_acc);
          addr_acc[3:0] = nib;
        end
        nbcd_pkg::PH_A2: addr_acc[7:4] = nib;
        nbcd_pkg::PH_A3: addr_acc[11:8] = nib;
        nbcd_pkg::PH_M1: instr_acc[7:4] = nib;
        nbcd_pkg::PH_M2: instr_acc[3:0] = nib;
        nbcd_pkg::PH_X2: x2_nibble = nib;
        default: ;
      endcase
      cur_phase = nxt;
      r.phase = nxt;
      r.data_nibble = nib;
      r.instr_address = addr_acc;
      r.instr_byte = instr_acc;
      r.pending_kind = kind_now;
      r.pending_operand = operand_now;
      r.nibble_at_x2 = x2_nibble;
      r.cycle_done = (nxt == nbcd_pkg::PH_X3);
      decoded_beats.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    nbcd_pkg::out_beat_t want;
    if (!rst_n) begin
      locked = 1'b0;
      cur_phase = nbcd_pkg::PH_A1;
      addr_acc = '0;
      instr_acc = '0;
      kind_now = nbcd_pkg::KIND_NORMAL;
      operand_now = '0;
      x2_nibble = '0;
      decoded_beats.delete();
      results_checked <= 0;
      kinds_seen <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %p", $time, out_data);
          fail_count++;
        end else begin
          want = decoded_beats.pop_front();
          check_field("phase", int'(want.phase), int'(out_data.phase));
          check_field("data_nibble", int'(want.data_nibble), int'(out_data.data_nibble));
          check_field("instr_address", int'(want.instr_address),
                      int'(out_data.instr_address));
          check_field("instr_byte", int'(want.instr_byte), int'(out_data.instr_byte));
          check_field("pending_kind", int'(want.pending_kind), int'(out_data.pending_kind));
          check_field("pending_operand", int'(want.pending_operand),
                      int'(out_data.pending_operand));
          check_field("nibble_at_x2", int'(want.nibble_at_x2), int'(out_data.nibble_at_x2));
          check_field("cycle_done", int'(want.cycle_done), int'(out_data.cycle_done));
          results_checked <= results_checked + 1;
          kinds_seen[want.pending_kind] <= 1'b1;
        end
      end
      if (in_valid && !in_stall) begin
        decode_sample(in_data);
      end
    end
    results_left <= decoded_beats.size();
  end

endmodule

/* verif/tb_nibble_bus_cycle_decoder.sv */
module tb_nibble_bus_cycle_decoder;

  localparam int QuietLimit    = 1000;
  localparam int ItemsPerPhase = 320;
  localparam int LongHold      = 80;
  localparam logic [31:0] JumpCycle  = 32'h9F3A450F;
  localparam logic [31:0] FetchCycle = 32'h87602321;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  nbcd_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  nbcd_pkg::out_beat_t out_data;

  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_request = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         gen_pos = 0;
  int         samples_sent = 0;
  int         fail_count;
  int         results_left;
  int         results_checked;
  logic [7:0] kinds_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nibble_bus_cycle_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  nbcd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .results_left   (results_left),
    .results_checked(results_checked),
    .kinds_seen     (kinds_seen)
  );

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("[nibble_bus_cycle_decoder] ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  task automatic send_beat(input logic [3:0] pins, input logic sync_lvl, input logic ok);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= nbcd_pkg::in_beat_t'{pins, sync_lvl, ok};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_cycle(input logic [31:0] nibs);
    for (int i = 0; i < 8; i++) begin
      send_beat(~nibs[i*4 +: 4], (i != 7), 1'b1);
    end
  endtask

  // Mostly well-formed cycles with sync on every eighth sample, with rare
  // clock-order errors, flipped sync levels and jumps in the cycle position.
  task automatic send_random();
    logic [3:0] nib;
    logic       sync_lvl;
    logic       ok;
    int         r;
    r = $urandom_range(199);
    nib = 4'($urandom_range(15));
    if (gen_pos == int'(nbcd_pkg::PH_M1) && $urandom_range(1)) begin
      case ($urandom_range(4))
        0: nib = nbcd_pkg::OPC_COND_JUMP;
        1: nib = nbcd_pkg::OPC_FETCH_IMM;
        2: nib = nbcd_pkg::OPC_JUMP;
        3: nib = nbcd_pkg::OPC_CALL;
        default: nib = nbcd_pkg::OPC_INC_SKIP;
      endcase
    end
    sync_lvl = (gen_pos != int'(nbcd_pkg::PH_X3));
    ok = 1'b1;
    if (r < 3) begin
      ok = 1'b0;
    end else if (r < 6) begin
      sync_lvl = !sync_lvl;
    end else if (r < 7) begin
      gen_pos = $urandom_range(7);
    end
    gen_pos = (gen_pos + 1) % 8;
    send_beat(~nib, sync_lvl, ok);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(4'h0, 1'b1, 1'b1);
    send_beat(4'h0, 1'b0, 1'b0);
    send_beat(4'hF, 1'b0, 1'b1);
    send_cycle(JumpCycle);
    send_cycle(FetchCycle);
    send_beat(~4'hC, 1'b1, 1'b1);
    send_beat(~4'h3, 1'b1, 1'b0);
    send_beat(~4'h0, 1'b0, 1'b1);
    send_beat(~4'h0, 1'b0, 1'b1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        3: begin idle_pct = 32; stall_pct = 32; end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_request = LongHold;
        end
      endcase
      repeat (ItemsPerPhase) send_random();
    end

    in_valid <= 1'b0;
    while (results_left != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Drove %0d bus samples under five idle and stall mixes, one with a %0d-cycle hold.",
             samples_sent, LongHold);
    $display("Checked %0d result beats; pending kinds observed (bit per kind): %b.",
             results_checked, kinds_seen[5:0]);
    if (fail_count == 0) begin
      $display("[nibble_bus_cycle_decoder] OK");
    end else begin
      $display("[nibble_bus_cycle_decoder] ERROR");
    end
    $finish;
  end

endmodule
